FILE: rtl/afhc_pkg.sv
// Shared types, codes and constants of the autofocus search sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package afhc_pkg;

  // Search phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COARSE,
    PH_FINE,
    PH_EXTRA,
    PH_CLIMB
  } phase_t;

  // Input item kinds
  localparam logic [1:0] MODE_FULL   = 2'd0;
  localparam logic [1:0] MODE_NEAR   = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  // Result actions
  localparam logic [1:0] ACT_MOVE  = 2'd0;
  localparam logic [1:0] ACT_FINAL = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;
  localparam logic [1:0] ACT_ABORT = 2'd3;

  // Climb point awaited from the next report
  localparam logic [1:0] PT_CENTER = 2'd0;
  localparam logic [1:0] PT_LOW    = 2'd1;
  localparam logic [1:0] PT_HIGH   = 2'd2;

  // Climb decision
  localparam logic [1:0] DIR_END   = 2'd0;
  localparam logic [1:0] DIR_LOW   = 2'd1;
  localparam logic [1:0] DIR_HIGH  = 2'd2;
  localparam logic [1:0] DIR_HALVE = 2'd3;

  // Configuration register indexes
  localparam logic REG_MIN_POSITION = 1'b0;
  localparam logic REG_MAX_POSITION = 1'b1;

  localparam logic [15:0] MIN_POSITION_RESET = 16'd0;
  localparam logic [15:0] MAX_POSITION_RESET = 16'd10000;

  // Climb distance below which the search finishes
  localparam int MIN_DISTANCE = 10;

  // Constant division by reciprocal: q = (a * ceil(2^S / d)) >> S,
  // exact for a < 2^16 and d <= 15.
  localparam int RECIP_SHIFT = 21;
  typedef logic [21:0] recip_t;
  localparam recip_t RECIP_FIFTH = recip_t'(((2 ** RECIP_SHIFT) + 4) / 5);
  localparam recip_t RECIP_THIRD = recip_t'(((2 ** RECIP_SHIFT) + 2) / 3);

  typedef logic signed [17:0] pos_t;
  typedef logic signed [16:0] step_t;
  typedef logic [31:0]        metric_t;

  // Range-derived values, refreshed on every configuration write
  typedef struct packed {
    logic [15:0] min_pos;
    logic [15:0] max_pos;
    step_t       coarse_div;  // range / COARSE_STEPS
    step_t       clamp;       // range / 5
    step_t       near_dist;   // range / COARSE_STEPS / 16
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    pos_t       target;
  } result_t;

  // Unsigned magnitude times reciprocal
  function automatic logic [15:0] recip_mul(logic [15:0] mag, recip_t recip);
    logic [37:0] prod;
    prod = {22'd0, mag} * {16'd0, recip};
    return prod[RECIP_SHIFT +: 16];
  endfunction

  // Signed division by a constant, truncating toward zero
  function automatic step_t sdiv_const(step_t v, recip_t recip);
    logic [16:0] mag;
    logic [15:0] q;
    mag = v[16] ? (17'd0 - v) : v;
    q   = recip_mul(mag[15:0], recip);
    return v[16] ? step_t'(17'd0 - {1'b0, q}) : step_t'({1'b0, q});
  endfunction

endpackage

`default_nettype wire

FILE: rtl/afhc_cfg.sv
// Range registers and the values derived from them by constant division.
// Depends on afhc_pkg.
`default_nettype none

module afhc_cfg import afhc_pkg::*; #(
  parameter int COARSE_STEPS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        we,
  input  wire logic        index,
  input  wire logic [15:0] wdata,
  output cfg_t             cfg_o
);

  localparam recip_t RECIP_N =
    recip_t'(((2 ** RECIP_SHIFT) + COARSE_STEPS - 1) / COARSE_STEPS);

  logic [15:0] min_r, min_nxt;
  logic [15:0] max_r, max_nxt;
  step_t       span;
  step_t       cdiv;
  step_t       cdiv_mag;
  cfg_t        der_r, der_nxt;

  // Register writes, reset folded in so derived values track at once
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (!rst_n) begin
      min_nxt = MIN_POSITION_RESET;
      max_nxt = MAX_POSITION_RESET;
    end else if (we) begin
      if (index == REG_MIN_POSITION) min_nxt = wdata;
      if (index == REG_MAX_POSITION) max_nxt = wdata;
    end
  end

  // Derived range values
  always_comb begin
    span     = step_t'({1'b0, max_nxt}) - step_t'({1'b0, min_nxt});
    cdiv     = sdiv_const(span, RECIP_N);
    cdiv_mag = cdiv[16] ? (17'sd0 - cdiv) : cdiv;
    der_nxt.min_pos    = min_nxt;
    der_nxt.max_pos    = max_nxt;
    der_nxt.coarse_div = cdiv;
    der_nxt.clamp      = sdiv_const(span, RECIP_FIFTH);
    der_nxt.near_dist  = cdiv[16] ? (17'sd0 - (cdiv_mag >>> 4)) : (cdiv >>> 4);
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
    der_r <= der_nxt;
  end

  assign cfg_o = der_r;

endmodule

`default_nettype wire

FILE: rtl/afhc_core.sv
// Search state and the per-item step: scans, extra measurement, hill climb.
// Depends on afhc_pkg; takes derived range values from afhc_cfg.
`default_nettype none

module afhc_core import afhc_pkg::*; #(
  parameter int COARSE_STEPS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg_i,
  input  wire logic        accept,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] cur_pos,
  input  wire metric_t     metric,
  input  wire logic        measure_ok,
  output logic             res_valid,
  output result_t          res
);

  localparam recip_t RECIP_N =
    recip_t'(((2 ** RECIP_SHIFT) + COARSE_STEPS - 1) / COARSE_STEPS);
  localparam logic [3:0]        LAST_IDX = 4'(COARSE_STEPS - 1);
  localparam logic signed [4:0] HALF_S   = 5'(COARSE_STEPS / 2);
  localparam logic signed [4:0] LAST_OFF = 5'(COARSE_STEPS - 1 - COARSE_STEPS / 2);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  metric_t     best_m_r, best_m_nxt;
  pos_t        best_p_r, best_p_nxt;
  step_t       cstep_r, cstep_nxt;
  step_t       fstep_r;
  step_t       fs3_r;
  pos_t        cen_p_r, cen_p_nxt;
  pos_t        low_p_r, low_p_nxt;
  pos_t        high_p_r, high_p_nxt;
  logic [13:0] dist_r, dist_nxt;
  metric_t     low_m_r, low_m_nxt;
  metric_t     cen_m_r, cen_m_nxt;
  metric_t     high_m_r, high_m_nxt;
  logic [1:0]  await_r, await_nxt;

  pos_t              min_s, max_s, clamp_s;
  logic signed [21:0] cmul, fmul_cur, fmul_next, fmul_last;
  logic signed [4:0] off_cur, off_next;
  pos_t              coarse_pos, fine_pos;
  logic              better;
  pos_t              scan_best_p;
  metric_t           scan_best_m;

  metric_t           m_l, m_c, m_h;
  logic [1:0]        dir;

  pos_t              en_pc, en_d, d_cl, en_low, en_high, sub_v, add_v;
  logic              en_final;

  // Scan arithmetic
  always_comb begin
    min_s     = pos_t'({2'b00, cfg_i.min_pos});
    max_s     = pos_t'({2'b00, cfg_i.max_pos});
    clamp_s   = pos_t'(cfg_i.clamp);
    cmul      = cstep_r * $signed({1'b0, idx_r});
    off_cur   = $signed({1'b0, idx_r}) - HALF_S;
    off_next  = off_cur - 5'sd1;
    fmul_cur  = fstep_r * off_cur;
    fmul_next = fstep_r * off_next;
    fmul_last = fstep_r * LAST_OFF;
    coarse_pos = min_s + pos_t'(cmul);
    fine_pos   = best_p_r + pos_t'(fmul_cur);
    better     = measure_ok && (metric > best_m_r);
  end

  // Metrics with this report folded in
  always_comb begin
    m_c = cen_m_r;
    m_l = low_m_r;
    m_h = high_m_r;
    case (await_r)
      PT_CENTER: m_c = metric;
      PT_LOW:    m_l = metric;
      default:   m_h = metric;
    endcase
  end

  // Three-point decision
  always_comb begin
    if (m_l == m_c && m_c == m_h)      dir = DIR_END;
    else if (m_l == m_c && m_c > m_h)  dir = DIR_LOW;
    else if (m_l < m_c && m_c == m_h)  dir = DIR_HIGH;
    else if (m_l < m_c && m_c > m_h)   dir = DIR_HALVE;
    else if (m_l > m_c && m_c >= m_h)  dir = DIR_LOW;
    else if (m_l <= m_c && m_c < m_h)  dir = DIR_HIGH;
    else if (m_l >= m_h)               dir = DIR_LOW;
    else                               dir = DIR_HIGH;
  end

  // Climb round entry: source of centre and distance
  always_comb begin
    en_pc = cen_p_r;
    en_d  = pos_t'({4'd0, dist_r});
    if (mode == MODE_NEAR) begin
      en_pc = pos_t'({2'b00, cur_pos});
      en_d  = pos_t'(cfg_i.near_dist);
    end else if (phase_r == PH_EXTRA) begin
      en_pc = best_p_r;
      en_d  = pos_t'(fs3_r);
    end else begin
      case (dir)
        DIR_LOW:  en_pc = low_p_r;
        DIR_HIGH: en_pc = high_p_r;
        DIR_HALVE: begin
          en_pc = cen_p_r;
          en_d  = pos_t'({5'd0, dist_r[13:1]});
        end
        default:  en_pc = cen_p_r;
      endcase
    end
    d_cl     = (en_d > clamp_s) ? clamp_s : en_d;
    en_final = d_cl < pos_t'(MIN_DISTANCE);
    sub_v    = en_pc - d_cl;
    add_v    = en_pc + d_cl;
    en_low   = (sub_v < min_s) ? min_s : sub_v;
    en_high  = (add_v > max_s) ? max_s : add_v;
  end

  // Step of one accepted item
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    best_m_nxt = best_m_r;
    best_p_nxt = best_p_r;
    cstep_nxt  = cstep_r;
    cen_p_nxt  = cen_p_r;
    low_p_nxt  = low_p_r;
    high_p_nxt = high_p_r;
    dist_nxt   = dist_r;
    low_m_nxt  = low_m_r;
    cen_m_nxt  = cen_m_r;
    high_m_nxt = high_m_r;
    await_nxt  = await_r;
    res_valid  = 1'b0;
    res.action = ACT_MOVE;
    res.target = cen_p_r;
    scan_best_p = best_p_r;
    scan_best_m = best_m_r;

    if (accept) begin
      if (mode == MODE_FULL) begin
        cstep_nxt  = cfg_i.coarse_div;
        best_m_nxt = '0;
        best_p_nxt = '0;
        idx_nxt    = '0;
        phase_nxt  = PH_COARSE;
        res_valid  = 1'b1;
        res.target = min_s;
      end else if (mode == MODE_NEAR ||
                   (mode == MODE_REPORT && phase_r == PH_EXTRA)) begin
        // new climb from a fresh start
        low_m_nxt  = '0;
        cen_m_nxt  = '0;
        high_m_nxt = '0;
        res_valid  = 1'b1;
        if (en_final) begin
          res.action = ACT_FINAL;
          res.target = en_pc;
          phase_nxt  = PH_IDLE;
        end else begin
          cen_p_nxt  = en_pc;
          dist_nxt   = d_cl[13:0];
          low_p_nxt  = en_low;
          high_p_nxt = en_high;
          phase_nxt  = PH_CLIMB;
          await_nxt  = PT_CENTER;
          res.target = en_pc;
        end
      end else if (mode == MODE_REPORT) begin
        case (phase_r)
          PH_COARSE: begin
            res_valid = 1'b1;
            if (better) begin
              scan_best_m = metric;
              scan_best_p = coarse_pos;
            end
            best_m_nxt = scan_best_m;
            best_p_nxt = scan_best_p;
            if (idx_r == LAST_IDX) begin
              phase_nxt  = PH_FINE;
              res.target = scan_best_p + pos_t'(fmul_last);
            end else begin
              idx_nxt    = idx_r + 4'd1;
              res.target = coarse_pos + pos_t'(cstep_r);
            end
          end
          PH_FINE: begin
            res_valid = 1'b1;
            if (better) begin
              scan_best_m = metric;
              scan_best_p = fine_pos;
            end
            best_m_nxt = scan_best_m;
            best_p_nxt = scan_best_p;
            if (idx_r == 4'd0) begin
              phase_nxt  = PH_EXTRA;
              res.target = scan_best_p;
            end else begin
              idx_nxt    = idx_r - 4'd1;
              res.target = scan_best_p + pos_t'(fmul_next);
            end
          end
          PH_CLIMB: begin
            res_valid = 1'b1;
            if (!measure_ok) begin
              res.action = ACT_ABORT;
              phase_nxt  = PH_IDLE;
            end else begin
              cen_m_nxt  = m_c;
              low_m_nxt  = m_l;
              high_m_nxt = m_h;
              if (await_r == PT_CENTER && m_l == '0) begin
                await_nxt  = PT_LOW;
                res.target = low_p_r;
              end else if ((await_r == PT_CENTER || await_r == PT_LOW) &&
                           m_h == '0) begin
                await_nxt  = PT_HIGH;
                res.target = high_p_r;
              end else if (dir == DIR_END ||
                           (dir == DIR_LOW && low_p_r == cen_p_r) ||
                           (dir == DIR_HIGH && high_p_r == cen_p_r)) begin
                res.action = ACT_END;
                phase_nxt  = PH_IDLE;
              end else begin
                // move or halve, then enter the next round
                case (dir)
                  DIR_LOW: begin
                    cen_m_nxt = m_l;
                    low_m_nxt = '0;
                  end
                  DIR_HIGH: begin
                    cen_m_nxt  = m_h;
                    high_m_nxt = '0;
                  end
                  default: begin
                    low_m_nxt  = '0;
                    high_m_nxt = '0;
                  end
                endcase
                if (en_final) begin
                  res.action = ACT_FINAL;
                  res.target = en_pc;
                  phase_nxt  = PH_IDLE;
                end else begin
                  cen_p_nxt  = en_pc;
                  dist_nxt   = d_cl[13:0];
                  low_p_nxt  = en_low;
                  high_p_nxt = en_high;
                  // a cleared side always exists here
                  if (cen_m_nxt == '0) begin
                    await_nxt  = PT_CENTER;
                    res.target = en_pc;
                  end else if (low_m_nxt == '0) begin
                    await_nxt  = PT_LOW;
                    res.target = en_low;
                  end else begin
                    await_nxt  = PT_HIGH;
                    res.target = en_high;
                  end
                end
              end
            end
          end
          default: res_valid = 1'b0;
        endcase
      end
    end
  end

  // State registers; fine step and climb start distance follow coarse step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      idx_r    <= '0;
      best_m_r <= '0;
      best_p_r <= '0;
      cstep_r  <= '0;
      fstep_r  <= '0;
      fs3_r    <= '0;
      cen_p_r  <= '0;
      low_p_r  <= '0;
      high_p_r <= '0;
      dist_r   <= '0;
      low_m_r  <= '0;
      cen_m_r  <= '0;
      high_m_r <= '0;
      await_r  <= PT_CENTER;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      best_m_r <= best_m_nxt;
      best_p_r <= best_p_nxt;
      cstep_r  <= cstep_nxt;
      fstep_r  <= sdiv_const(cstep_r <<< 1, RECIP_N);
      fs3_r    <= sdiv_const(fstep_r, RECIP_THIRD);
      cen_p_r  <= cen_p_nxt;
      low_p_r  <= low_p_nxt;
      high_p_r <= high_p_nxt;
      dist_r   <= dist_nxt;
      low_m_r  <= low_m_nxt;
      cen_m_r  <= cen_m_nxt;
      high_m_r <= high_m_nxt;
      await_r  <= await_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/afhc_obuf.sv
// Two-entry result buffer between the step logic and the output channel.
// Depends on afhc_pkg.
`default_nettype none

module afhc_obuf import afhc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         not_full,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr;
  logic       pop;
  result_t    ent_r [2];

  always_comb begin
    out_valid  = cnt_r != 2'd0;
    not_full   = cnt_r != 2'd2;
    pop        = out_valid && out_ready;
    wr_ptr     = rd_ptr_r ^ cnt_r[0];
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_ptr_nxt = rd_ptr_r ^ pop;
    out_data   = ent_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

FILE: rtl/autofocus_hill_climb_sequencer.sv
// Top level of the autofocus search sequencer: range registers, step logic
// and result buffer. Depends on afhc_pkg, afhc_cfg, afhc_core, afhc_obuf.
//
//  Channel  Direction  Content
//  in_      slave      start full / start near / measurement report
//  out_     master     move request, final move, ended in place, aborted
//  cfg_     write      min_position (index 0), max_position (index 1)
//
// One item per cycle while in_tready is high: each accepted item is handled in the
// cycle it is taken, and its result (if any) is registered in the result buffer.
// A two-entry result buffer lets input continue while a result waits;
// in_tready drops only when both entries are occupied.
// Reset is synchronous on rst_n, clears the search to idle and restores
// the range to 0..10000. No clearing pass is needed.
`default_nettype none

module autofocus_hill_climb_sequencer import afhc_pkg::*; #(
  parameter int COARSE_STEPS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // current_position[15:0], metric[47:16]
  input  wire logic [2:0]  in_tuser,   // mode[1:0], measure_ok[2]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // target_position[17:0], zero[23:18]
  output logic [1:0]       out_tuser,  // action[1:0]
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = in_tvalid && in_tready;

  afhc_cfg #(
    .COARSE_STEPS (COARSE_STEPS)
  ) u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg_o (cfg)
  );

  afhc_core #(
    .COARSE_STEPS (COARSE_STEPS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .accept     (accept),
    .mode       (in_tuser[1:0]),
    .cur_pos    (in_tdata[15:0]),
    .metric     (in_tdata[47:16]),
    .measure_ok (in_tuser[2]),
    .res_valid  (res_valid),
    .res        (res)
  );

  afhc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .not_full  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {6'd0, out_res.target};
  assign out_tuser = out_res.action;

endmodule

`default_nettype wire
